// File: sv/framebuffer_text_console_cursor_macros.svh
// Assertion macros for the text console cursor controller.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef FRAMEBUFFER_TEXT_CONSOLE_CURSOR_MACROS_SVH
`define FRAMEBUFFER_TEXT_CONSOLE_CURSOR_MACROS_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is high
`define FBC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fbc assertion failed");
// Clocked check that also holds during reset
`define FBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fbc assertion failed");
`else
`define FBC_ASSERT(lbl, clk, rst, prop)
`define FBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/fbc_pkg.sv
// Shared types, codes, palette and helper functions for the text console cursor controller.
// No dependencies; used by fbc_regs, fbc_core and the top level.
package fbc_pkg;

  // Command modes
  localparam logic [1:0] MODE_PUT = 2'd0;
  localparam logic [1:0] MODE_SET = 2'd1;
  localparam logic [1:0] MODE_CLR = 2'd2;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Tab stop spacing and mask
  localparam logic [8:0] TAB_STEP = 9'd8;
  localparam logic [8:0] TAB_MASK = ~9'd7;

  // Register map (word index)
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_SWAP = 2'd2;

  localparam int         ADDR_W     = 4;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;

  // 16-entry CGA palette, red in the high byte
  localparam logic [23:0] CGA_PALETTE [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic       swap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         char_code;
    logic [7:0]         char_attr;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
  } item_t;

  typedef struct packed {
    logic        draw_valid;
    logic [7:0]  draw_col;
    logic [7:0]  draw_row;
    logic [7:0]  glyph_code;
    logic [23:0] fg_pixel;
    logic [23:0] bg_pixel;
    logic        scroll_up;
    logic        clear_all;
    logic [7:0]  new_col;
    logic [7:0]  new_row;
  } res_t;

  // Palette lookup with optional red/blue byte swap
  function automatic logic [23:0] cga_pixel(input logic [3:0] idx, input logic swap);
    logic [23:0] rgb;
    rgb = CGA_PALETTE[idx];
    if (swap) begin
      rgb = {rgb[7:0], rgb[15:8], rgb[23:16]};
    end
    return rgb;
  endfunction

  // Clamp a signed request to 0..lim-1 (lim is 1..255)
  function automatic logic [7:0] clamp_req(input logic signed [15:0] v, input logic [8:0] lim);
    logic [8:0] last;
    last = lim - 9'd1;
    if (v[15]) begin
      return 8'd0;
    end else if (v < $signed({7'd0, lim})) begin
      return v[7:0];
    end else begin
      return last[7:0];
    end
  endfunction

endpackage

// File: sv/fbc_regs.sv
// APB-style configuration registers: grid size and pixel byte order.
// Depends on fbc_pkg.
module fbc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output fbc_pkg::cfg_t               cfg
);
  import fbc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols <= COLS_RESET;
      cfg.rows <= ROWS_RESET;
      cfg.swap <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COLS: cfg.cols <= pwdata[7:0];
        REG_ROWS: cfg.rows <= pwdata[7:0];
        REG_SWAP: cfg.swap <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_COLS: prdata = {24'd0, cfg.cols};
      REG_ROWS: prdata = {24'd0, cfg.rows};
      REG_SWAP: prdata = {31'd0, cfg.swap};
      default:  prdata = '0;
    endcase
  end

endmodule

// File: sv/fbc_core.sv
// Cursor state register and the per-command update logic (draw, wrap, scroll, clamp).
// Depends on fbc_pkg and the assertion macro header.
`include "framebuffer_text_console_cursor_macros.svh"
module fbc_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  fbc_pkg::cfg_t  cfg,
  input  fbc_pkg::item_t item,
  output fbc_pkg::res_t  res
);
  import fbc_pkg::*;

  logic [7:0] cur_col;
  logic [7:0] cur_row;

  logic [8:0] cols9, rows9, col9, row9;
  logic [8:0] row_inc, col_inc, tab9, lim_m1;
  logic [7:0] nl_row;
  logic       nl_scr;
  logic [7:0] bs_col;
  logic       in_grid, bs_in_grid;

  // Grid size, zero treated as one; 9-bit compares so nothing wraps
  always_comb begin
    cols9   = (cfg.cols == 8'd0) ? 9'd1 : {1'b0, cfg.cols};
    rows9   = (cfg.rows == 8'd0) ? 9'd1 : {1'b0, cfg.rows};
    col9    = {1'b0, cur_col};
    row9    = {1'b0, cur_row};
    row_inc = row9 + 9'd1;
    col_inc = col9 + 9'd1;
    tab9    = (col9 + TAB_STEP) & TAB_MASK;
    lim_m1  = rows9 - 9'd1;
    bs_col  = cur_col - 8'd1;
    // next line: bottom row requests a scroll
    nl_scr  = (row_inc >= rows9);
    nl_row  = nl_scr ? lim_m1[7:0] : row_inc[7:0];
    in_grid    = (col9 < cols9) && (row9 < rows9);
    bs_in_grid = ({1'b0, bs_col} < cols9) && (row9 < rows9);
  end

  // Command decode
  always_comb begin
    res         = '0;
    res.new_col = cur_col;
    res.new_row = cur_row;
    case (item.mode)
      MODE_PUT: begin
        case (item.char_code)
          CH_LF: begin
            res.new_col   = 8'd0;
            res.new_row   = nl_row;
            res.scroll_up = nl_scr;
          end
          CH_CR: res.new_col = 8'd0;
          CH_BS: begin
            if (cur_col != 8'd0) begin
              res.new_col = bs_col;
              if (bs_in_grid) begin
                res.draw_valid = 1'b1;
                res.draw_col   = bs_col;
                res.draw_row   = cur_row;
                res.glyph_code = CH_SPACE;
                res.fg_pixel   = cga_pixel(item.char_attr[3:0], cfg.swap);
                res.bg_pixel   = cga_pixel(item.char_attr[7:4], cfg.swap);
              end
            end
          end
          CH_TAB: begin
            if (tab9 >= cols9) begin
              res.new_col   = 8'd0;
              res.new_row   = nl_row;
              res.scroll_up = nl_scr;
            end else begin
              res.new_col = tab9[7:0];
            end
          end
          default: begin
            if (in_grid) begin
              res.draw_valid = 1'b1;
              res.draw_col   = cur_col;
              res.draw_row   = cur_row;
              res.glyph_code = item.char_code;
              res.fg_pixel   = cga_pixel(item.char_attr[3:0], cfg.swap);
              res.bg_pixel   = cga_pixel(item.char_attr[7:4], cfg.swap);
            end
            // advance, wrapping at the last column
            if (col_inc >= cols9) begin
              res.new_col   = 8'd0;
              res.new_row   = nl_row;
              res.scroll_up = nl_scr;
            end else begin
              res.new_col = col_inc[7:0];
            end
          end
        endcase
      end
      MODE_SET: begin
        res.new_col = clamp_req(item.cursor_x, cols9);
        res.new_row = clamp_req(item.cursor_y, rows9);
      end
      MODE_CLR: begin
        res.clear_all = 1'b1;
        res.new_col   = 8'd0;
        res.new_row   = 8'd0;
      end
      default: ;
    endcase
  end

  // Cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= 8'd0;
      cur_row <= 8'd0;
    end else if (adv) begin
      cur_col <= res.new_col;
      cur_row <= res.new_row;
    end
  end

  `FBC_ASSERT(a_cursor_follows, clk, rst, adv |=> (cur_col == $past(res.new_col)) && (cur_row == $past(res.new_row)))
  `FBC_ASSERT(a_cursor_holds, clk, rst, !adv |=> $stable(cur_col) && $stable(cur_row))
  `FBC_ASSERT(a_draw_in_grid, clk, rst, res.draw_valid |-> ({1'b0, res.draw_col} < cols9) && ({1'b0, res.draw_row} < rows9))

endmodule

// File: sv/framebuffer_text_console_cursor.sv
// Text console cursor controller, top level.
// Commands enter on the input channel (mode, char_code, char_attr, cursor_x, cursor_y)
// under in_valid/in_stall; one transaction is taken at each edge with valid high and
// stall low. Every command gives exactly one result transaction on out_valid/out_stall:
// the draw request for a glyph cell (position, glyph, 24-bit fg/bg pixels), the scroll
// and clear requests, and the cursor position after the command.
// A command accepted into the input register passes through the cursor logic into the
// output register once that register is free or being drained, and out_valid then rises.
// One command per cycle while the receiver does not stall; the cursor update is a single
// pass of compare and increment logic feeding back into the cursor register.
// When the receiver stalls, the result is held and the input register keeps one more
// command; once both are full, in_stall is raised until the output is taken.
// Grid size and red/blue order are set through the APB port; the user must do so only
// while the block is idle; the block itself does not enforce it. Synchronous reset empties
// both registers, homes the cursor and loads an 80x25 grid with red in the high byte.
// Depends on fbc_pkg, fbc_regs, fbc_core and the assertion macro header.
`include "framebuffer_text_console_cursor_macros.svh"
module framebuffer_text_console_cursor (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // command channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [7:0]                 char_code,
  input  logic [7:0]                 char_attr,
  input  logic signed [15:0]         cursor_x,
  input  logic signed [15:0]         cursor_y,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       draw_valid,
  output logic [7:0]                 draw_col,
  output logic [7:0]                 draw_row,
  output logic [7:0]                 glyph_code,
  output logic [23:0]                fg_pixel,
  output logic [23:0]                bg_pixel,
  output logic                       scroll_up,
  output logic                       clear_all,
  output logic [7:0]                 new_col,
  output logic [7:0]                 new_row
);
  import fbc_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res_comb;
  res_t  res;
  logic  item_valid;
  logic  adv;
  logic  in_take;

  fbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the held command moves on when the output register is free or drained
  assign adv      = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{mode: mode, char_code: char_code, char_attr: char_attr,
                cursor_x: cursor_x, cursor_y: cursor_y};
    end
  end

  fbc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .cfg  (cfg),
    .item (item),
    .res  (res_comb)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_comb;
    end
  end

  assign draw_valid = res.draw_valid;
  assign draw_col   = res.draw_col;
  assign draw_row   = res.draw_row;
  assign glyph_code = res.glyph_code;
  assign fg_pixel   = res.fg_pixel;
  assign bg_pixel   = res.bg_pixel;
  assign scroll_up  = res.scroll_up;
  assign clear_all  = res.clear_all;
  assign new_col    = res.new_col;
  assign new_row    = res.new_row;

  `FBC_ASSERT(a_nodraw_zero, clk, rst, (out_valid && !draw_valid) |-> (draw_col == 8'd0) && (draw_row == 8'd0) && (glyph_code == 8'd0) && (fg_pixel == 24'd0) && (bg_pixel == 24'd0))
  `FBC_ASSERT(a_clear_homes, clk, rst, (out_valid && clear_all) |-> (new_col == 8'd0) && (new_row == 8'd0) && !draw_valid && !scroll_up)
  `FBC_ASSERT(a_scroll_col0, clk, rst, (out_valid && scroll_up) |-> (new_col == 8'd0))
  `FBC_ASSERT_ALWAYS(a_no_accept_in_reset, clk, rst |=> !out_valid && !in_stall)

endmodule
